// ===== hw/rtl/chol_pkg.sv =====
// cholesky decomposition: shared types and constants
// no dependencies
package chol_pkg;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [3:0] SIZE_RESET = 4'd8;

	typedef struct packed {
		logic [2:0] row_index;
		logic [2:0] col_index;
		logic signed [31:0] element_value;
		logic last_element;
	} in_beat_t;

	typedef struct packed {
		logic [2:0] out_row;
		logic [2:0] out_col;
		logic signed [31:0] factor_value;
		logic pivot_replaced;
		logic divide_saturated;
		logic not_pos_definite;
		logic last_result;
	} out_beat_t;

	// request from the sequencer to the iterative unit
	typedef struct packed {
		logic start;
		logic is_sqrt;
	} op_req_t;
endpackage

// ===== hw/rtl/chol_if.sv =====
// valid/ready channel interfaces
// depends on chol_pkg
interface chol_in_if;
	chol_pkg::in_beat_t data;
	logic valid;
	logic ready;
	modport source(output data, output valid, input ready);
	modport sink(input data, input valid, output ready);
endinterface

interface chol_out_if;
	chol_pkg::out_beat_t data;
	logic valid;
	logic ready;
	modport source(output data, output valid, input ready);
	modport sink(input data, input valid, output ready);
endinterface

interface chol_cfg_if;
	logic [3:0] data;
	logic valid;
	logic ready;
	modport source(output data, output valid, input ready);
	modport sink(input data, input valid, output ready);
endinterface

// ===== hw/rtl/chol_ram.sv =====
// generic single-write, single-read ram with registered read
// no dependencies
module chol_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 36
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/chol_divsqrt.sv =====
// iterative bit-serial unit: signed q16 division or integer square root
// depends on chol_pkg
module chol_divsqrt (
	input logic clk,
	input logic arst_n,
	input chol_pkg::op_req_t req,
	input logic signed [31:0] rem,
	input logic signed [31:0] divisor,
	output logic busy,
	output logic done,
	output logic signed [31:0] result
);
	import chol_pkg::*;

	logic [47:0] x_q;
	logic [47:0] quo_q;
	logic [48:0] part_q;
	logic [31:0] dabs_q;
	logic neg_q;
	logic sq_q;
	logic [5:0] cnt_q;
	logic [49:0] sq_rem_q;
	logic [24:0] sq_root_q;

	logic [48:0] part_sh;
	logic [49:0] sq_trial;
	logic [49:0] sq_rsh;
	logic [47:0] qmag;

	assign part_sh = {part_q[47:0], x_q[47]};
	assign sq_rsh = {sq_rem_q[47:0], x_q[47:46]};
	assign sq_trial = {23'd0, sq_root_q, 2'b01};
	assign qmag = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy <= 1'b1;
				sq_q <= req.is_sqrt;
				part_q <= '0;
				quo_q <= '0;
				sq_rem_q <= '0;
				sq_root_q <= '0;
				if (req.is_sqrt) begin
					x_q <= {rem[31:0], 16'd0};
					cnt_q <= 6'd24;
				end else begin
					x_q <= {rem[31] ? -rem : rem, 16'd0};
					dabs_q <= divisor[31] ? -divisor : divisor;
					neg_q <= rem[31] ^ divisor[31];
					cnt_q <= 6'd48;
				end
			end else if (busy) begin
				if (sq_q) begin
					x_q <= {x_q[45:0], 2'b00};
					if (sq_rsh >= sq_trial) begin
						sq_rem_q <= sq_rsh - sq_trial;
						sq_root_q <= {sq_root_q[23:0], 1'b1};
					end else begin
						sq_rem_q <= sq_rsh;
						sq_root_q <= {sq_root_q[23:0], 1'b0};
					end
				end else begin
					x_q <= {x_q[46:0], 1'b0};
					if (part_sh >= {17'd0, dabs_q}) begin
						part_q <= part_sh - {17'd0, dabs_q};
						quo_q <= {quo_q[46:0], 1'b1};
					end else begin
						part_q <= part_sh;
						quo_q <= {quo_q[46:0], 1'b0};
					end
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (sq_q) result = {7'd0, sq_root_q};
		else if (!neg_q) result = (qmag > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : qmag[31:0];
		else result = (qmag > 48'h8000_0000) ? 32'sh8000_0000 : -qmag[31:0];
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) req.start |-> !busy)
		else $error("start while busy");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("done without work");
endmodule

// ===== hw/rtl/chol_seq.sv =====
// sequencer: loads the triangle, walks the factorization, emits results
// depends on chol_pkg, chol_ram, chol_divsqrt
module chol_seq #(
	parameter int MAX_DIM = 8
) (
	input logic clk,
	input logic arst_n,
	input logic [3:0] matrix_size,
	input logic in_valid,
	output logic in_ready,
	input chol_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output chol_pkg::out_beat_t out_data
);
	import chol_pkg::*;

	localparam int DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
	localparam int AW = $clog2(DEPTH);
	localparam int DW = $clog2(MAX_DIM + 1);

	typedef enum logic [3:0] {
		S_LOAD, S_ELEM, S_RDA, S_RDK, S_MAC, S_MUL, S_ACC, S_REM, S_WAIT, S_EMIT
	} state_t;

	state_t state_q;
	logic [DW-1:0] n_q, i_q, j_q, k_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] li_q, lj_q, res_q;
	logic signed [63:0] prod_q;
	logic piv_q, dsat_q, neg_seen_q;
	logic [AW-1:0] ra_a, ra_f, wa_f, wa_a;
	logic [31:0] rd_a, rd_f;
	logic we_a, we_f;
	logic rk_phase_q;
	op_req_t req;
	logic ds_busy, ds_done;
	logic signed [31:0] ds_res, rem_sat;

	function automatic logic [AW-1:0] tri_pos(input logic [DW-1:0] r, input logic [DW-1:0] c);
		logic [2*DW-1:0] t;
		t = ({{DW{1'b0}}, r} * ({{DW{1'b0}}, r} + 1'b1)) >> 1;
		return AW'(t + c);
	endfunction

	assign in_ready = (state_q == S_LOAD) && !out_valid;
	assign we_a = in_valid && in_ready && (in_data.col_index <= in_data.row_index) &&
		(32'(in_data.row_index) < MAX_DIM);
	assign wa_a = tri_pos(DW'(in_data.row_index), DW'(in_data.col_index));

	always_comb begin
		ra_a = tri_pos(i_q, j_q);
		ra_f = rk_phase_q ? tri_pos(j_q, k_q) : tri_pos(i_q, k_q);
		// divisor fetch ahead of the remainder cycle
		if ((state_q == S_RDA || state_q == S_ACC) && k_q == j_q) ra_f = tri_pos(j_q, j_q);
	end

	assign we_f = (state_q == S_EMIT) && !out_valid;
	assign wa_f = tri_pos(i_q, j_q);

	chol_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
		.clk(clk), .we(we_a), .waddr(wa_a), .wdata(in_data.element_value),
		.raddr(ra_a), .rdata(rd_a));
	chol_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_f (
		.clk(clk), .we(we_f), .waddr(wa_f), .wdata(res_q),
		.raddr(ra_f), .rdata(rd_f));

	assign rem_sat = (acc_q > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
		(acc_q < -64'sh8000_0000) ? 32'sh8000_0000 : acc_q[31:0];

	always_comb begin
		req.start = (state_q == S_REM) && !((i_q == j_q) && rem_sat[31]) &&
			!((i_q != j_q) && (rd_f == 32'd0));
		req.is_sqrt = (i_q == j_q);
	end

	chol_divsqrt u_ds (
		.clk(clk), .arst_n(arst_n), .req(req), .rem(rem_sat), .divisor(rd_f),
		.busy(ds_busy), .done(ds_done), .result(ds_res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			out_valid <= 1'b0;
			neg_seen_q <= 1'b0;
			rk_phase_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_LOAD: if (in_valid && in_ready && in_data.last_element) begin
					n_q <= (matrix_size == 4'd0) ? DW'(1) :
						(32'(matrix_size) > MAX_DIM) ? DW'(MAX_DIM) : DW'(matrix_size);
					i_q <= '0;
					j_q <= '0;
					neg_seen_q <= 1'b0;
					state_q <= S_ELEM;
				end
				S_ELEM: begin
					k_q <= '0;
					rk_phase_q <= 1'b0;
					piv_q <= 1'b0;
					dsat_q <= 1'b0;
					state_q <= S_RDA;
				end
				S_RDA: begin
					acc_q <= 64'(signed'(rd_a));
					state_q <= (k_q == j_q) ? S_REM : S_RDK;
					rk_phase_q <= 1'b1;
				end
				S_RDK: begin
					li_q <= rd_f;
					rk_phase_q <= 1'b0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					lj_q <= rd_f;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= li_q * lj_q;
					k_q <= k_q + 1'b1;
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_q - (prod_q >>> 16);
					rk_phase_q <= 1'b1;
					state_q <= (k_q == j_q) ? S_REM : S_RDK;
				end
				S_REM: begin
					if (i_q == j_q && rem_sat[31]) begin
						res_q <= ONE_Q16;
						piv_q <= 1'b1;
						neg_seen_q <= 1'b1;
						state_q <= S_EMIT;
					end else if (i_q != j_q && rd_f == 32'd0) begin
						dsat_q <= 1'b1;
						res_q <= rem_sat[31] ? 32'sh8000_0000 :
							(rem_sat != 0) ? 32'sh7FFF_FFFF : 32'sd0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: if (ds_done) begin
					res_q <= ds_res;
					state_q <= S_EMIT;
				end
				S_EMIT: if (!out_valid) begin
					out_valid <= 1'b1;
					out_data.out_row <= 3'(i_q);
					out_data.out_col <= 3'(j_q);
					out_data.factor_value <= res_q;
					out_data.pivot_replaced <= piv_q;
					out_data.divide_saturated <= dsat_q;
					out_data.last_result <= (i_q == n_q - 1'b1) && (j_q == i_q);
					out_data.not_pos_definite <= (i_q == n_q - 1'b1) && (j_q == i_q) &&
						(neg_seen_q || piv_q);
					if (j_q == i_q) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						state_q <= (i_q == n_q - 1'b1) ? S_LOAD : S_ELEM;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_ELEM;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) we_f |-> state_q == S_EMIT)
		else $error("factor write outside emit");
	assert property (@(posedge clk) disable iff (!arst_n) ds_busy |-> state_q == S_WAIT)
		else $error("unit busy outside wait");
	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> !ds_busy)
		else $error("loading during factorization");
endmodule

// ===== hw/rtl/cholesky_decomposition_core.sv =====
// cholesky decomposition core, top level
// depends on chol_pkg, chol_if, chol_seq
//
// in: one beat per lower-triangle element (row, col, q16.16 value, last mark).
// elements above the diagonal or beyond MAX_DIM are dropped. a beat with the
// last mark stores its element and starts the factorization of the leading
// matrix_size rows; no further input is taken until all results are out.
// out: one beat per factor element in row-major order, last_result on the
// final one, with not_pos_definite set there if any pivot was replaced.
// cfg: writes matrix_size (resets to 8); write only while idle.
// loading accepts one element per cycle while no result is waiting. each factor
// element passes setup (S_ELEM, S_RDA), S_RDK, S_MAC, S_MUL and S_ACC per inner
// product term, the shared bit-serial unit (square root or division), then emit.
// each result waits in the output register; while the receiver stalls the
// sequencer holds. reset returns to loading; memory contents are not cleared.
module cholesky_decomposition_core #(
	parameter int MAX_DIM = 8
) (
	input logic clk,
	input logic arst_n,
	chol_cfg_if.sink cfg,
	chol_in_if.sink in_ch,
	chol_out_if.source out_ch
);
	import chol_pkg::*;

	logic [3:0] size_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= SIZE_RESET;
		else if (cfg.valid) size_q <= cfg.data;
	end

	chol_seq #(.MAX_DIM(MAX_DIM)) u_seq (
		.clk(clk), .arst_n(arst_n), .matrix_size(size_q),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
endmodule

// ===== dv/cholesky_decomposition_checker.sv =====
// checker for the cholesky decomposition core: watches the cfg, input and output channels,
// predicts every factor beat in q16.16 and compares in order; depends on chol_pkg, chol_if
module cholesky_decomposition_checker (
	input logic clk,
	input logic arst_n,
	chol_cfg_if cfg,
	chol_in_if in_ch,
	chol_out_if out_ch,
	output int errors,
	output int outstanding
);
	import chol_pkg::*;

	localparam int DIM = 8;
	localparam int TRI = DIM * (DIM + 1) / 2;

	logic signed [31:0] a_store [TRI];
	logic signed [31:0] l_store [TRI];
	logic [3:0] size_reg;
	out_beat_t expected_factor_q [$];
	int mismatches;

	assign errors = mismatches;
	assign outstanding = expected_factor_q.size();

	function automatic int tri_idx(int r, int c);
		return r * (r + 1) / 2 + c;
	endfunction

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r = 0;
		longint unsigned b = 64'h1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic factorize();
		int n;
		longint acc;
		longint prod;
		logic signed [31:0] rem, res, dv;
		logic piv, dsat, any_piv;
		out_beat_t b;
		n = (size_reg == 0) ? 1 : ((size_reg > DIM) ? DIM : int'(size_reg));
		any_piv = 0;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j <= i; j++) begin
				acc = longint'(a_store[tri_idx(i, j)]);
				piv = 0;
				dsat = 0;
				for (int k = 0; k < j; k++) begin
					prod = longint'(l_store[tri_idx(i, k)]) * longint'(l_store[tri_idx(j, k)]);
					acc -= (prod >>> 16);
				end
				rem = sat32(acc);
				if (i == j) begin
					if (rem < 0) begin
						res = ONE_Q16;
						piv = 1;
						any_piv = 1;
					end else begin
						res = 32'(int_sqrt(longint'(rem) << 16));
					end
				end else begin
					dv = l_store[tri_idx(j, j)];
					if (dv == 0) begin
						dsat = 1;
						res = (rem > 0) ? 32'sh7fff_ffff : ((rem < 0) ? 32'sh8000_0000 : 32'sh0);
					end else begin
						res = sat32((longint'(rem) * 65536) / longint'(dv));
					end
				end
				l_store[tri_idx(i, j)] = res;
				b.out_row = i[2:0];
				b.out_col = j[2:0];
				b.factor_value = res;
				b.pivot_replaced = piv;
				b.divide_saturated = dsat;
				b.not_pos_definite = (i == n - 1 && j == i) ? any_piv : 1'b0;
				b.last_result = (i == n - 1 && j == i);
				expected_factor_q.push_back(b);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_beat_t got, want;
		if (!arst_n) begin
			size_reg = SIZE_RESET;
			expected_factor_q.delete();
		end else begin
			if (cfg.valid && cfg.ready)
				size_reg = cfg.data;
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.data.col_index <= in_ch.data.row_index)
					a_store[tri_idx(in_ch.data.row_index, in_ch.data.col_index)] =
						in_ch.data.element_value;
				if (in_ch.data.last_element)
					factorize();
			end
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (expected_factor_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected factor beat row %0d col %0d value %h",
							got.out_row, got.out_col, got.factor_value);
				end else begin
					want = expected_factor_q.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch exp r%0d c%0d v%h piv%b dsat%b npd%b last%b",
								" got r%0d c%0d v%h piv%b dsat%b npd%b last%b"},
								want.out_row, want.out_col, want.factor_value,
								want.pivot_replaced, want.divide_saturated,
								want.not_pos_definite, want.last_result,
								got.out_row, got.out_col, got.factor_value,
								got.pivot_replaced, got.divide_saturated,
								got.not_pos_definite, got.last_result);
					end
				end
			end
		end
	end

	initial mismatches = 0;
endmodule

// ===== dv/cholesky_decomposition_core_tb.sv =====
// testbench top for the cholesky decomposition core: loads matrices of many sizes and kinds,
// writes matrix_size between runs, stalls both sides; depends on chol_pkg, chol_if, the checker
module cholesky_decomposition_core_tb;
	import chol_pkg::*;

	localparam int KIND_PD = 0;
	localparam int KIND_RAND = 1;
	localparam int KIND_ZERO_DIAG = 2;
	localparam int KIND_NEG_DIAG = 3;
	localparam int KIND_EXTREME = 4;

	logic clk;
	logic arst_n;
	int errors, outstanding;
	int items_sent;
	bit quiet, hold_req, held;

	chol_cfg_if cfg();
	chol_in_if in_ch();
	chol_out_if out_ch();

	cholesky_decomposition_core dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
	);

	cholesky_decomposition_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		out_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
				out_ch.ready <= 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_ch.ready <= 1;
			end else begin
				out_ch.ready <= 1;
			end
		end
	end

	task automatic send_beat(logic [2:0] r, logic [2:0] c, logic [31:0] v, logic last);
		in_ch.valid <= 1;
		in_ch.data <= '{row_index: r, col_index: c, element_value: v, last_element: last};
		forever begin
			@(negedge clk);
			if (in_ch.ready) break;
		end
		@(posedge clk);
		items_sent++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_ch.valid <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_size(logic [3:0] s);
		cfg.valid <= 1;
		cfg.data <= s;
		forever begin
			@(negedge clk);
			if (cfg.ready) break;
		end
		@(posedge clk);
		cfg.valid <= 0;
	endtask

	function automatic logic [31:0] pick_value(int kind, int i, int j);
		logic [31:0] ext [6] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1,
			32'hffff_ffff, 32'h0001_0000};
		case (kind)
			KIND_RAND: return $urandom;
			KIND_EXTREME: return ext[$urandom_range(0, 5)];
			default: begin
				if (i == j) begin
					if (kind == KIND_ZERO_DIAG && $urandom_range(0, 1)) return 0;
					if (kind == KIND_NEG_DIAG && $urandom_range(0, 2) == 0)
						return -$urandom_range(1, 32'h40_0000);
					return $urandom_range(32'h4_0000, 32'h40_0000);
				end
				return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
			end
		endcase
	endfunction

	// loads every lower-triangle element of the leading n rows in random order, with occasional above-diagonal noise beats
	task automatic load_matrix(int n, int kind);
		int pos [$];
		int p, r, c;
		bit last_on_noise;
		for (int i = 0; i < n; i++)
			for (int j = 0; j <= i; j++)
				pos.push_back(i * 8 + j);
		pos.shuffle();
		last_on_noise = ($urandom_range(0, 7) == 0);
		foreach (pos[k]) begin
			p = pos[k];
			if ($urandom_range(0, 9) == 0) begin
				r = $urandom_range(0, 6);
				send_beat(3'(r), 3'($urandom_range(r + 1, 7)), $urandom, 1'b0);
			end
			send_beat(3'(p / 8), 3'(p % 8), pick_value(kind, p / 8, p % 8),
				(k == pos.size() - 1) && !last_on_noise);
		end
		if (last_on_noise)
			send_beat(3'd2, 3'd5, $urandom, 1'b1);
		wait_idle();
	endtask

	function automatic int eff_size(logic [3:0] s);
		return (s == 0) ? 1 : ((s > 8) ? 8 : int'(s));
	endfunction

	initial begin
		logic [3:0] s;
		int n;
		arst_n = 0;
		items_sent = 0;
		quiet = 0;
		hold_req = 0;
		held = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		cfg.valid = 0;
		cfg.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_size(4'd1);
		send_beat(3'd0, 3'd0, 32'h7fff_ffff, 1'b1);
		wait_idle();
		send_beat(3'd0, 3'd0, 32'h8000_0000, 1'b1);
		wait_idle();
		send_beat(3'd0, 3'd0, 32'h0, 1'b1);
		wait_idle();
		write_size(4'd0);
		send_beat(3'd0, 3'd0, 32'h0004_0000, 1'b1);
		wait_idle();
		write_size(4'd2);
		send_beat(3'd0, 3'd0, 32'h0, 1'b0);
		send_beat(3'd1, 3'd0, 32'h0001_0000, 1'b0);
		send_beat(3'd1, 3'd1, 32'h0002_0000, 1'b1);
		wait_idle();
		send_beat(3'd1, 3'd0, 32'hffff_0000, 1'b1);
		wait_idle();
		send_beat(3'd0, 3'd0, 32'h0, 1'b0);
		send_beat(3'd1, 3'd0, 32'h0, 1'b1);
		wait_idle();
		write_size(4'd3);
		load_matrix(3, KIND_NEG_DIAG);
		send_beat(3'd0, 3'd7, 32'h1234_5678, 1'b1);
		wait_idle();
		write_size(4'd15);
		load_matrix(8, KIND_PD);

		while (items_sent < 280) begin
			if (items_sent > 220) quiet = 1;
			case ($urandom_range(0, 9))
				0: s = 4'd8;
				1: s = 4'($urandom_range(9, 15));
				2: s = 4'd0;
				3, 4: s = 4'($urandom_range(5, 7));
				default: s = 4'($urandom_range(1, 4));
			endcase
			write_size(s);
			n = eff_size(s);
			if (items_sent > 100 && !held && !quiet) begin
				hold_req = 1;
				held = 1;
			end
			load_matrix(n, $urandom_range(0, 9) < 5 ? KIND_PD : $urandom_range(1, 4));
			if ($urandom_range(0, 4) == 0) begin
				send_beat(3'($urandom_range(0, n - 1)), 3'd0, pick_value(KIND_PD, 1, 0),
					1'b1);
				wait_idle();
			end
		end
		wait_idle();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
